FILE: hw/rtl/moore_cellular_automaton_top_assert.svh
// Assertion macros shared by the automaton RTL.
// Self-contained; defining ASSERT_OFF leaves every macro empty.
`ifndef MOORE_CELLULAR_AUTOMATON_TOP_ASSERT_SVH
`define MOORE_CELLULAR_AUTOMATON_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define CMA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cma assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define CMA_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cma assertion failed");
`else
`define CMA_ASSERT(name, clk, rst_n, prop)
`define CMA_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/cma_pkg.sv
// Shared constants, types and helper functions of the cellular automaton.
// No dependencies; every RTL module imports this package.
package cma_pkg;

  // Grid limits
  localparam int unsigned MAX_ROWS    = 64;
  localparam int unsigned MAX_COLUMNS = 64;

  // Field and register widths
  localparam int unsigned ROW_W      = 64;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned GEN_W      = 8;
  localparam int unsigned THR_W      = 4;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ROW_IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_IDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // Neighbourhood
  localparam int unsigned NBR_N     = 8;
  localparam int unsigned NBR_CNT_W = 4;

  // Register reset values
  localparam logic [CNT_W-1:0] RST_ROWS = CNT_W'(64);
  localparam logic [CNT_W-1:0] RST_COLS = CNT_W'(64);
  localparam logic [GEN_W-1:0] RST_GENS = GEN_W'(1);
  localparam logic [THR_W-1:0] RST_THR  = THR_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS,
    REG_GRID_COLUMNS,
    REG_GENERATIONS,
    REG_ALIVE_THRESHOLD
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_DRAIN,
    ST_OUT
  } cma_state_e;

  // Three consecutive rows around the row being updated
  typedef struct packed {
    logic [ROW_W-1:0] up;
    logic [ROW_W-1:0] cur;
    logic [ROW_W-1:0] dn;
  } cma_window_t;

  // Clamp the row count into 1..MAX_ROWS
  function automatic logic [CNT_W-1:0] eff_rows(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (int'(v) > int'(MAX_ROWS)) r = CNT_W'(MAX_ROWS);
    else r = v;
    return r;
  endfunction

  // Clamp the column count into 1..MAX_COLUMNS
  function automatic logic [CNT_W-1:0] eff_cols(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] c;
    if (v == '0) c = CNT_W'(1);
    else if (int'(v) > int'(MAX_COLUMNS)) c = CNT_W'(MAX_COLUMNS);
    else c = v;
    return c;
  endfunction

  // Ones in every column below the column count
  function automatic logic [ROW_W-1:0] col_mask(input logic [CNT_W-1:0] cols);
    logic [ROW_W-1:0] m;
    for (int x = 0; x < ROW_W; x++) begin
      m[x] = (x < int'(cols));
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/cma_grid_ram.sv
// Grid row store: one write port and one read port with registered read data.
// Depends on cma_pkg for depth and widths.
module cma_grid_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [cma_pkg::ROW_IDX_W-1:0] waddr_i,
  input  logic [cma_pkg::ROW_W-1:0]     wdata_i,
  input  logic                          re_i,
  input  logic [cma_pkg::ROW_IDX_W-1:0] raddr_i,
  output logic [cma_pkg::ROW_W-1:0]     rdata_o
);
  import cma_pkg::*;

  logic [ROW_W-1:0] mem [MAX_ROWS];
  logic [ROW_W-1:0] rdata_q;

  // Write one row
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one row into the output register
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/cma_lane.sv
// One cell lane: counts the live neighbours and compares with the threshold.
// Depends on cma_pkg for widths.
module cma_lane (
  input  logic [cma_pkg::NBR_N-1:0] nbr_i,
  input  logic [cma_pkg::THR_W-1:0] thr_i,
  output logic                      alive_o
);
  import cma_pkg::*;

  logic [NBR_CNT_W-1:0] cnt;

  // Add up the eight neighbour bits
  always_comb begin
    cnt = '0;
    for (int k = 0; k < NBR_N; k++) begin
      cnt = cnt + NBR_CNT_W'(nbr_i[k]);
    end
  end

  // A threshold above eight is never reached, zero is always met
  assign alive_o = (cnt >= thr_i);

endmodule

FILE: hw/rtl/cma_row_update.sv
// Row update: one lane per column works on the three-row window, and the
// merging stage assembles the lane results into a masked row. Uses cma_pkg, cma_lane.
module cma_row_update (
  input  cma_pkg::cma_window_t          win_i,
  input  logic [cma_pkg::CNT_W-1:0]     cols_i,
  input  logic [cma_pkg::THR_W-1:0]     thr_i,
  output logic [cma_pkg::ROW_W-1:0]     row_o
);
  import cma_pkg::*;

  logic [COL_IDX_W-1:0] cols_m1;
  logic [ROW_W-1:0]     lane_alive;

  assign cols_m1 = COL_IDX_W'(cols_i - CNT_W'(1));

  // Build the wrapped neighbourhood of every column and evaluate it
  for (genvar x = 0; x < ROW_W; x++) begin : g_lane
    if (x < MAX_COLUMNS) begin : g_act
      logic up_l, up_r, cur_l, cur_r, dn_l, dn_r;

      // Left neighbour wraps to the last used column
      if (x == 0) begin : g_lwrap
        assign up_l  = win_i.up[cols_m1];
        assign cur_l = win_i.cur[cols_m1];
        assign dn_l  = win_i.dn[cols_m1];
      end else begin : g_lplain
        assign up_l  = win_i.up[x-1];
        assign cur_l = win_i.cur[x-1];
        assign dn_l  = win_i.dn[x-1];
      end

      // Right neighbour of the last used column wraps to column zero
      if (x == MAX_COLUMNS - 1) begin : g_rwrap
        assign up_r  = win_i.up[0];
        assign cur_r = win_i.cur[0];
        assign dn_r  = win_i.dn[0];
      end else begin : g_rsel
        assign up_r  = (cols_m1 == COL_IDX_W'(x)) ? win_i.up[0]  : win_i.up[x+1];
        assign cur_r = (cols_m1 == COL_IDX_W'(x)) ? win_i.cur[0] : win_i.cur[x+1];
        assign dn_r  = (cols_m1 == COL_IDX_W'(x)) ? win_i.dn[0]  : win_i.dn[x+1];
      end

      cma_lane u_lane (
        .nbr_i   ({up_l, win_i.up[x], up_r, cur_l, cur_r, dn_l, win_i.dn[x], dn_r}),
        .thr_i   (thr_i),
        .alive_o (lane_alive[x])
      );
    end else begin : g_off
      assign lane_alive[x] = 1'b0;
    end
  end

  // Merge the lanes and drop columns beyond the column count
  assign row_o = lane_alive & col_mask(cols_i);

endmodule

FILE: hw/rtl/moore_cellular_automaton_top.sv
// Toroidal Moore-neighbourhood cellular automaton: row store, sweep sequencer,
// output register. Uses cma_pkg, cma_grid_ram, cma_row_update and the assert header.
//
// Usage. The input channel (in_valid_i / in_stall_o) carries one grid row per
// transaction, bit x being column x; last_row_i ends a load. Rows load at one
// per cycle. Rows beyond the row count are dropped; rows not supplied keep
// their earlier contents. After the last row the block runs the configured
// generations: each generation streams the rows from the grid store, one
// store read per cycle, through a three-row window and the column lanes,
// writing updated rows back in place, and then drains the window. Afterwards
// it emits every row on the output channel (out_valid_o / out_stall_i), the
// last one flagged by final_row_o; the next row is read from the store only
// when the output register is free or its row is being taken. A stalled
// result holds in the output register while the next load is already accepted.
// in_stall_o is high from the last row until the cycle after the last result
// row reaches the output register. Reset sets the registers to their defaults
// (64 rows, 64 columns, one generation, threshold five) and clears the load
// count; the grid store itself is not cleared, so there is no clearing pass.
// Write the configuration only while the block is idle.
`include "moore_cellular_automaton_top_assert.svh"

module moore_cellular_automaton_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cma_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cma_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cma_pkg::ROW_W-1:0]      row_bits_i,
  input  logic                           last_row_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cma_pkg::ROW_W-1:0]      result_row_o,
  output logic                           final_row_o
);
  import cma_pkg::*;

  // Configuration registers
  logic [CNT_W-1:0] rows_q, cols_q;
  logic [GEN_W-1:0] gens_q;
  logic [THR_W-1:0] thr_q;
  logic [CNT_W-1:0] rows_eff, cols_eff;
  logic [ROW_W-1:0] mask;

  // Sequencer
  cma_state_e       state_q, state_d;
  logic [CNT_W-1:0] load_cnt_q, rd_cnt_q, out_cnt_q;
  logic [GEN_W-1:0] gen_cnt_q;

  // Sweep pipeline
  logic                 arr_vld_q, tail_q, done_q, win_vld_q;
  logic [CNT_W-1:0]     arr_idx_q;
  cma_window_t          win_q;
  logic [ROW_W-1:0]     row0_q;
  logic [ROW_IDX_W-1:0] win_row_q;
  logic [ROW_W-1:0]     new_row;

  // Output path
  logic             pend_q, pend_last_q, out_vld_q, out_last_q;
  logic [ROW_W-1:0] out_row_q;

  // Handshakes and store ports
  logic                 in_accept, out_take, load_wr, sweep_rd, out_rd;
  logic                 ram_we, ram_re;
  logic [ROW_IDX_W-1:0] ram_waddr, ram_raddr, sweep_addr;
  logic [ROW_W-1:0]     ram_wdata, ram_rdata;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RST_ROWS;
      cols_q <= RST_COLS;
      gens_q <= RST_GENS;
      thr_q  <= RST_THR;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GRID_ROWS:       rows_q <= cfg_data_i[CNT_W-1:0];
        REG_GRID_COLUMNS:    cols_q <= cfg_data_i[CNT_W-1:0];
        REG_GENERATIONS:     gens_q <= cfg_data_i[GEN_W-1:0];
        REG_ALIVE_THRESHOLD: thr_q  <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows_eff = eff_rows(rows_q);
  assign cols_eff = eff_cols(cols_q);
  assign mask     = col_mask(cols_eff);

  // Handshakes
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_vld_q && !out_stall_i;

  // Store port selection: the load owns the write port while loading
  assign sweep_rd   = (state_q == ST_READ);
  assign sweep_addr = (rd_cnt_q == '0) ? ROW_IDX_W'(rows_eff - CNT_W'(1))
                                       : ROW_IDX_W'(rd_cnt_q - CNT_W'(1));
  assign out_rd     = (state_q == ST_OUT) && !pend_q && (out_cnt_q < rows_eff) &&
                      (!out_vld_q || out_take);
  assign load_wr    = in_accept && (load_cnt_q < rows_eff);
  assign ram_we     = load_wr || win_vld_q;
  assign ram_waddr  = load_wr ? ROW_IDX_W'(load_cnt_q) : win_row_q;
  assign ram_wdata  = load_wr ? (row_bits_i & mask) : new_row;
  assign ram_re     = sweep_rd || out_rd;
  assign ram_raddr  = sweep_rd ? sweep_addr : ROW_IDX_W'(out_cnt_q);

  cma_grid_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cma_row_update u_row (
    .win_i  (win_q),
    .cols_i (cols_eff),
    .thr_i  (thr_q),
    .row_o  (new_row)
  );

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Choose the next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_accept && last_row_i) begin
          state_d = (gens_q == '0) ? ST_OUT : ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt_q == rows_eff) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done_q) state_d = (gen_cnt_q == GEN_W'(1)) ? ST_OUT : ST_READ;
      end
      ST_OUT: begin
        if ((out_cnt_q == rows_eff) && !pend_q) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Advance the counters and the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      rd_cnt_q   <= '0;
      out_cnt_q  <= '0;
      gen_cnt_q  <= '0;
      arr_vld_q  <= 1'b0;
      tail_q     <= 1'b0;
      done_q     <= 1'b0;
      win_vld_q  <= 1'b0;
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      // Load count: clamp at the row count, restart after the last row
      if (in_accept) begin
        if (last_row_i) load_cnt_q <= '0;
        else if (load_cnt_q < rows_eff) load_cnt_q <= load_cnt_q + CNT_W'(1);
        else load_cnt_q <= rows_eff;
      end

      // Start a run at the end of a load
      if (in_accept && last_row_i) begin
        gen_cnt_q <= gens_q;
        rd_cnt_q  <= '0;
        out_cnt_q <= '0;
      end

      // Sweep reads: the last row first, then rows zero to the last
      if (sweep_rd) begin
        rd_cnt_q <= (rd_cnt_q == rows_eff) ? '0 : rd_cnt_q + CNT_W'(1);
      end
      if ((state_q == ST_DRAIN) && done_q) gen_cnt_q <= gen_cnt_q - GEN_W'(1);

      arr_vld_q <= sweep_rd;
      tail_q    <= arr_vld_q && (arr_idx_q == rows_eff);
      done_q    <= tail_q;
      win_vld_q <= (arr_vld_q && (arr_idx_q >= CNT_W'(2))) || tail_q;

      // Output reads, one in flight, only when the output register has room
      if (out_rd) out_cnt_q <= out_cnt_q + CNT_W'(1);
      pend_q <= out_rd;
      if (pend_q) out_vld_q <= 1'b1;
      else if (out_take) out_vld_q <= 1'b0;
    end
  end

  // Shift the row window; the saved row zero closes the torus
  always_ff @(posedge clk_i) begin
    arr_idx_q <= rd_cnt_q;
    if (arr_vld_q || tail_q) begin
      win_q.up  <= win_q.cur;
      win_q.cur <= win_q.dn;
      win_q.dn  <= tail_q ? row0_q : ram_rdata;
    end
    if (arr_vld_q && (arr_idx_q == CNT_W'(1))) row0_q <= ram_rdata;
    win_row_q <= tail_q ? ROW_IDX_W'(rows_eff - CNT_W'(1))
                        : ROW_IDX_W'(arr_idx_q - CNT_W'(2));
  end

  // Capture result rows
  always_ff @(posedge clk_i) begin
    pend_last_q <= (out_cnt_q == rows_eff - CNT_W'(1));
    if (pend_q) begin
      out_row_q  <= ram_rdata & mask;
      out_last_q <= pend_last_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign result_row_o = out_row_q;
  assign final_row_o  = out_last_q;

  // Write-back never collides with a load
  `CMA_ASSERT(a_wr_excl, clk_i, rst_ni, !(win_vld_q && (state_q == ST_LOAD)))
  // Read data for the output only arrives when the output register is free
  `CMA_ASSERT_IMPLY(a_out_room, clk_i, rst_ni, pend_q, !out_vld_q)
  // Written-back rows stay inside the grid
  `CMA_ASSERT_IMPLY(a_win_row, clk_i, rst_ni, win_vld_q,
                    win_row_q <= ROW_IDX_W'(rows_eff - CNT_W'(1)))
  // The sweep read counter never passes the row count
  `CMA_ASSERT_IMPLY(a_rd_bound, clk_i, rst_ni, state_q == ST_READ, rd_cnt_q <= rows_eff)
  // A sweep completes only while draining
  `CMA_ASSERT_IMPLY(a_done_drain, clk_i, rst_ni, done_q, state_q == ST_DRAIN)

endmodule
